>>> rtl/hgse_pkg.sv
// Package for the HTTP GET section extractor: types, codes and constants.
package hgse_pkg;

	// Capture limit default, in frame bytes
	localparam int unsigned MAX_FRAME_BYTES_DEF = 2048;

	// Configuration port
	localparam int unsigned APB_ADDR_W = 3;
	localparam int unsigned APB_DATA_W = 32;
	localparam logic REG_LINK_HDR = 1'b0;     // register index 0
	localparam logic [6:0] LINK_HDR_RESET = 7'd14;

	// Result queue
	localparam int unsigned QDEPTH = 4;
	localparam int unsigned QPTR_W = $clog2(QDEPTH);
	localparam int unsigned QCNT_W = $clog2(QDEPTH + 1);

	// Header and method constants
	localparam logic [5:0] MIN_HDR_LEN = 6'd20;
	localparam logic [7:0] CHAR_SPACE = 8'h20;
	localparam logic [7:0] CHAR_SLASH = 8'h2F;
	localparam logic [15:0] SECTION_START = 16'd4;
	localparam logic [15:0] METHOD_LEN = 16'd3;

	typedef enum logic [2:0] {
		PH_LINK    = 3'd0,
		PH_IP      = 3'd1,
		PH_TCP     = 3'd2,
		PH_METHOD  = 3'd3,
		PH_SECTION = 3'd4,
		PH_IDLE    = 3'd5
	} phase_t;

	typedef enum logic [2:0] {
		KIND_BYTE    = 3'd0,
		KIND_DONE    = 3'd1,
		KIND_BAD_IP  = 3'd2,
		KIND_BAD_TCP = 3'd3,
		KIND_TRUNC   = 3'd4
	} kind_t;

	typedef struct packed {
		logic [7:0] frame_byte;
		logic       frame_last;
	} in_item_t;

	typedef struct packed {
		kind_t      kind;
		logic [7:0] section_byte;
	} out_item_t;

	// Up to two results caused by one frame byte, in order
	typedef struct packed {
		logic [1:0] n;
		out_item_t  r0;
		out_item_t  r1;
	} res_pair_t;

	// Characters of the method word "GET"
	function automatic logic [7:0] get_char(input logic [1:0] idx);
		logic [7:0] c;
		case (idx)
			2'd0: c = 8'h47;
			2'd1: c = 8'h45;
			2'd2: c = 8'h54;
			default: c = 8'h00;
		endcase
		return c;
	endfunction

endpackage

>>> rtl/http_get_section_extractor_core.sv
// Top level of the HTTP GET section extractor: config register, input stage, parser, queue.
//
// Usage: feed captured frame bytes in order on the in channel (valid/ready),
// one request per byte, frame_last set on the final captured byte. Each byte
// gives zero, one or two results on the out channel (valid/ready), one per
// request: section characters of a GET request line (kind byte), then a
// done marker, or a bad ip / bad tcp header flag, or a truncated-frame flag.
// Path: a byte is held in the input register until the result queue has room,
// is then parsed into the queue, and its results are offered on the out
// channel from there.
// Throughput: one byte per cycle while the queue has room, set by the single
// parse step between the input register and the four-entry result queue. The input register drains
// only while the queue has two free slots, so when the receiver stalls the
// queue fills and in_ready drops; no result is lost or repeated.
// Reset: the link header length register returns to 14, the parser waits for
// link header byte 0 of a new frame, and both channels come up empty.
// The user must write the link header length (APB register 0) only between frames; the block does not enforce this.
module http_get_section_extractor_core #(
	parameter int unsigned MAX_FRAME_BYTES = hgse_pkg::MAX_FRAME_BYTES_DEF
) (
	input  logic                               clk,
	input  logic                               arst_n,
	// frame byte requests
	input  logic                               in_valid,
	output logic                               in_ready,
	input  hgse_pkg::in_item_t                 in_item,
	// result requests
	output logic                               out_valid,
	input  logic                               out_ready,
	output hgse_pkg::out_item_t                out_item,
	// configuration port
	input  logic                               psel,
	input  logic                               penable,
	input  logic                               pwrite,
	input  logic [hgse_pkg::APB_ADDR_W-1:0]    paddr,
	input  logic [hgse_pkg::APB_DATA_W-1:0]    pwdata,
	output logic [hgse_pkg::APB_DATA_W-1:0]    prdata,
	output logic                               pready
);
	import hgse_pkg::*;

	logic [6:0] link_hdr_q;   // link header length in bytes
	logic       v_s1;         // input register holds a byte
	in_item_t   item_s1;
	logic       room;         // queue can take a worst-case pair of results
	logic       step;         // parse the held byte this cycle
	res_pair_t  res;
	logic       reg_sel;

	// Register index comes from the word address
	assign reg_sel = paddr[APB_ADDR_W-1];
	assign pready = 1'b1;
	assign prdata = (reg_sel == REG_LINK_HDR) ? {{(APB_DATA_W-7){1'b0}}, link_hdr_q} : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			link_hdr_q <= LINK_HDR_RESET;
		end else if (psel && penable && pwrite && pready && reg_sel == REG_LINK_HDR) begin
			link_hdr_q <= pwdata[6:0];
		end
	end

	// Advance the held byte whenever the queue has room; refill in the same cycle
	assign step = v_s1 && room;
	assign in_ready = !v_s1 || room;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (in_ready) begin
			v_s1 <= in_valid;
		end
	end

	// Hold the payload until it is parsed
	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			item_s1 <= in_item;
		end
	end

	hgse_parse #(
		.MAX_FRAME_BYTES(MAX_FRAME_BYTES)
	) u_parse (
		.clk     (clk),
		.arst_n  (arst_n),
		.step    (step),
		.item    (item_s1),
		.link_hdr(link_hdr_q),
		.res     (res)
	);

	hgse_outq u_outq (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (step),
		.res      (res),
		.room     (room),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.out_item (out_item)
	);

	a_step_needs_byte: assert property (@(posedge clk) disable iff (!arst_n)
		step |-> v_s1)
		else $error("parse step without a held byte");

	a_stall_holds_byte: assert property (@(posedge clk) disable iff (!arst_n)
		(v_s1 && !room) |=> (v_s1 && $stable(item_s1)))
		else $error("held byte lost during stall");

	a_cfg_write_lands: assert property (@(posedge clk) disable iff (!arst_n)
		(psel && penable && pwrite && reg_sel == REG_LINK_HDR) |=>
		(link_hdr_q == $past(pwdata[6:0])))
		else $error("link header register write lost");

endmodule

>>> rtl/hgse_parse.sv
// Frame parser: header walk, method check and section extraction per byte.
module hgse_parse #(
	parameter int unsigned MAX_FRAME_BYTES = hgse_pkg::MAX_FRAME_BYTES_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              step,
	input  hgse_pkg::in_item_t item,
	input  logic [6:0]        link_hdr,
	output hgse_pkg::res_pair_t res
);
	import hgse_pkg::*;

	phase_t      phase_q, phase_d;
	logic [15:0] pos_q, pos_d;
	logic [5:0]  ihl_q, ihl_d;
	logic [15:0] itl_q, itl_d;
	logic [5:0]  thl_q, thl_d;
	logic [15:0] pp_q, pp_d;

	logic [16:0] ioff;
	logic [17:0] toff;
	logic [17:0] size;
	logic [17:0] pnext;
	logic        in_range;
	logic        cap_end;
	logic        size_ge3;
	logic        pay_end;

	assign ioff = {1'b0, pos_q} - {10'b0, link_hdr};
	assign toff = {2'b0, pos_q} - {11'b0, link_hdr} - {12'b0, ihl_q};
	assign size = {2'b0, itl_q} - {12'b0, ihl_q} - {12'b0, thl_q};
	assign pnext = {2'b0, pp_q} + 18'd1;
	assign in_range = {1'b0, pos_q} < 17'(MAX_FRAME_BYTES);
	assign cap_end = {1'b0, pos_q} >= 17'(MAX_FRAME_BYTES - 1);
	assign size_ge3 = !size[17] && (size >= {2'b0, METHOD_LEN});
	assign pay_end = $signed(pnext) >= $signed(size);

	always_comb begin
		phase_t     ph;
		logic       stop;
		out_item_t  r;
		logic [7:0] b;
		ph = phase_q;
		stop = 1'b0;
		b = item.frame_byte;
		r = '{kind: KIND_BYTE, section_byte: 8'h00};
		res = '{n: 2'd0, r0: r, r1: r};
		pos_d = pos_q;
		ihl_d = ihl_q;
		itl_d = itl_q;
		thl_d = thl_q;
		pp_d = pp_q;
		if (in_range) begin
			if (ph == PH_LINK && pos_q >= {9'b0, link_hdr}) begin
				ph = PH_IP;
			end
			case (ph)
				PH_IP: begin
					if (ioff == 17'd0) begin
						ihl_d = {b[3:0], 2'b00};
						if ({b[3:0], 2'b00} < MIN_HDR_LEN) begin
							res.r0 = '{kind: KIND_BAD_IP, section_byte: 8'h00};
							res.n = 2'd1;
							ph = PH_IDLE;
						end
					end else if (ioff == 17'd2) begin
						itl_d[15:8] = b;
					end else if (ioff == 17'd3) begin
						itl_d[7:0] = b;
					end
					if (ph == PH_IP && (ioff + 17'd1) == {11'b0, ihl_q}) begin
						ph = PH_TCP;
					end
				end
				PH_TCP: begin
					if (toff == 18'd12) begin
						thl_d = {b[7:4], 2'b00};
						if ({b[7:4], 2'b00} < MIN_HDR_LEN) begin
							res.r0 = '{kind: KIND_BAD_TCP, section_byte: 8'h00};
							res.n = 2'd1;
							ph = PH_IDLE;
						end
					end
					if (ph == PH_TCP && (toff[17] || toff >= 18'd12) &&
						(toff + 18'd1) == {12'b0, thl_q}) begin
						pp_d = 16'd0;
						ph = size_ge3 ? PH_METHOD : PH_IDLE;
					end
				end
				PH_METHOD, PH_SECTION: begin
					if (pp_q < METHOD_LEN) begin
						if (b != get_char(pp_q[1:0])) begin
							ph = PH_IDLE;
							stop = 1'b1;
						end
					end else if (pp_q >= SECTION_START) begin
						if (b == CHAR_SPACE || (b == CHAR_SLASH && pp_q > SECTION_START)) begin
							res.r0 = '{kind: KIND_DONE, section_byte: 8'h00};
							res.n = 2'd1;
							ph = PH_IDLE;
							stop = 1'b1;
						end else begin
							res.r0 = '{kind: KIND_BYTE, section_byte: b};
							res.n = 2'd1;
						end
					end
					if (!stop) begin
						if (pay_end) begin
							r = '{kind: KIND_DONE, section_byte: 8'h00};
							if (res.n == 2'd0) begin
								res.r0 = r;
							end else begin
								res.r1 = r;
							end
							res.n = res.n + 2'd1;
							ph = PH_IDLE;
						end else begin
							pp_d = pnext[15:0];
							if (pnext[15:0] >= SECTION_START) begin
								ph = PH_SECTION;
							end
						end
					end
				end
				default: begin
				end
			endcase
			pos_d = pos_q + 16'd1;
			if ((item.frame_last || cap_end) && ph != PH_IDLE) begin
				r = '{kind: KIND_TRUNC, section_byte: 8'h00};
				if (res.n == 2'd0) begin
					res.r0 = r;
				end else begin
					res.r1 = r;
				end
				res.n = res.n + 2'd1;
				ph = PH_IDLE;
			end
		end
		phase_d = ph;
		if (item.frame_last) begin
			pos_d = 16'd0;
			phase_d = PH_LINK;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_LINK;
			pos_q <= 16'd0;
			ihl_q <= 6'd0;
			itl_q <= 16'd0;
			thl_q <= 6'd0;
			pp_q <= 16'd0;
		end else if (step) begin
			phase_q <= phase_d;
			pos_q <= pos_d;
			ihl_q <= ihl_d;
			itl_q <= itl_d;
			thl_q <= thl_d;
			pp_q <= pp_d;
		end
	end

	a_byte_only_in_payload: assert property (@(posedge clk) disable iff (!arst_n)
		(step && res.n != 2'd0 && res.r0.kind == KIND_BYTE) |->
		(phase_q == PH_METHOD || phase_q == PH_SECTION))
		else $error("section byte emitted outside payload");

	a_last_restarts_frame: assert property (@(posedge clk) disable iff (!arst_n)
		(step && item.frame_last) |=> (pos_q == 16'd0 && phase_q == PH_LINK))
		else $error("frame end did not restart parsing");

	a_no_result_after_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(step && phase_q == PH_IDLE) |-> (res.n == 2'd0))
		else $error("result produced while idle in frame");

endmodule

>>> rtl/hgse_outq.sv
// Result queue: takes up to two results per cycle, hands out one per request.
module hgse_outq (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                push,
	input  hgse_pkg::res_pair_t res,
	output logic                room,
	output logic                out_valid,
	input  logic                out_ready,
	output hgse_pkg::out_item_t out_item
);
	import hgse_pkg::*;

	out_item_t          q [QDEPTH];
	logic [QPTR_W-1:0]  wp_q;
	logic [QPTR_W-1:0]  rp_q;
	logic [QCNT_W-1:0]  cnt_q;
	logic [1:0]         push_n;
	logic               pop;

	assign push_n = push ? res.n : 2'd0;
	assign pop = out_valid && out_ready;
	assign out_valid = cnt_q != '0;
	assign out_item = q[rp_q];
	// Two free slots guarantee space for the worst case of one byte
	assign room = cnt_q <= QCNT_W'(QDEPTH - 2);

	always_ff @(posedge clk) begin
		if (push_n != 2'd0) begin
			q[wp_q] <= res.r0;
		end
		if (push_n == 2'd2) begin
			q[wp_q + QPTR_W'(1)] <= res.r1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q <= '0;
			rp_q <= '0;
			cnt_q <= '0;
		end else begin
			wp_q <= wp_q + QPTR_W'(push_n);
			if (pop) begin
				rp_q <= rp_q + QPTR_W'(1);
			end
			cnt_q <= cnt_q + QCNT_W'(push_n) - QCNT_W'(pop);
		end
	end

	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= QCNT_W'(QDEPTH))
		else $error("result queue count out of range");

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		(push_n != 2'd0) |-> (cnt_q <= QCNT_W'(QDEPTH) - QCNT_W'(push_n)))
		else $error("result queue overflow");

endmodule
